@@ hdl/lfwr_pkg.sv @@
// Shared constants, types and helpers for the linked handle queue.
`timescale 1ns / 1ps

package lfwr_pkg;

    localparam int POOL_SIZE = 16;
    localparam int HDL_W     = $clog2(POOL_SIZE);
    localparam int SLOT_W    = HDL_W + 1;
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);

    localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(POOL_SIZE);

    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    localparam logic [1:0] RC_OK      = 2'd0;
    localparam logic [1:0] RC_EMPTY   = 2'd1;
    localparam logic [1:0] RC_REFUSED = 2'd2;
    localparam logic [1:0] RC_INVALID = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_QUEUED  = 2'd1,
        ST_READ    = 2'd2,
        ST_DELETED = 2'd3
    } slot_state_t;

    typedef enum logic {
        CTL_IDLE = 1'b0,
        CTL_EXEC = 1'b1
    } ctl_state_t;

    function automatic logic in_pool(input logic [SLOT_W-1:0] s);
        return s < SLOT_NONE;
    endfunction

endpackage

@@ hdl/linked_fifo_with_removal_core.sv @@
// Top level of the linked handle queue with push, pop and removal anywhere in the list.
`timescale 1ns / 1ps

// The block takes a new request only in its idle state and works on one at a time: when a
// transaction is accepted the next and previous link memories are read into registers, and
// in the execute state the links, head, tail, count and slot status are updated and the
// result is loaded into the output register. This read-then-write order is set by the link
// memories, which have a registered read port. A result that is not taken holds the
// update, so in_stall stays high until the output register is free again.
// Reset clears the status of all slots at once; no clearing pass is needed.
module linked_fifo_with_removal_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      action,
    input  logic [lfwr_pkg::HDL_W-1:0]      handle,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      result_code,
    output logic [lfwr_pkg::HDL_W-1:0]      popped_handle,
    output logic [lfwr_pkg::CNT_W-1:0]      queue_count
);

    lfwr_pkg::ctl_state_t state_reg, state_next;

    logic [1:0]                  act_reg;
    logic [lfwr_pkg::HDL_W-1:0]  hdl_reg;
    logic [lfwr_pkg::SLOT_W-1:0] rd_next_reg;
    logic [lfwr_pkg::SLOT_W-1:0] rd_prev_reg;

    logic [lfwr_pkg::SLOT_W-1:0] head_reg, head_next;
    logic [lfwr_pkg::SLOT_W-1:0] tail_reg, tail_next;
    logic [lfwr_pkg::CNT_W-1:0]  count_reg, count_next;

    lfwr_pkg::slot_state_t status_reg [lfwr_pkg::POOL_SIZE];

    logic [lfwr_pkg::SLOT_W-1:0] next_mem [lfwr_pkg::POOL_SIZE];
    logic [lfwr_pkg::SLOT_W-1:0] prev_mem [lfwr_pkg::POOL_SIZE];

    logic                        accept;
    logic                        exec_done;
    logic [lfwr_pkg::HDL_W-1:0]  rd_addr_next;

    logic                        next_we;
    logic [lfwr_pkg::HDL_W-1:0]  next_wa;
    logic [lfwr_pkg::SLOT_W-1:0] next_wd;
    logic                        prev_we;
    logic [lfwr_pkg::HDL_W-1:0]  prev_wa;
    logic [lfwr_pkg::SLOT_W-1:0] prev_wd;
    logic                        st_we;
    logic [lfwr_pkg::HDL_W-1:0]  st_wa;
    lfwr_pkg::slot_state_t       st_wd;

    logic [1:0]                  rc;
    logic [lfwr_pkg::HDL_W-1:0]  got;

    logic [lfwr_pkg::SLOT_W-1:0] hdl_slot;
    lfwr_pkg::slot_state_t       hdl_status;
    logic [lfwr_pkg::SLOT_W-1:0] link_nx;
    logic [lfwr_pkg::SLOT_W-1:0] link_pv;

    logic                        out_valid_reg;
    logic [1:0]                  result_code_reg;
    logic [lfwr_pkg::HDL_W-1:0]  popped_handle_reg;
    logic [lfwr_pkg::CNT_W-1:0]  queue_count_reg;

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfwr_pkg::CTL_IDLE:
            begin
                if (accept)
                begin
                    state_next = lfwr_pkg::CTL_EXEC;
                end
            end
            lfwr_pkg::CTL_EXEC:
            begin
                if (exec_done)
                begin
                    state_next = lfwr_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = lfwr_pkg::CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        exec_done = 1'b0;
        case (state_reg)
            lfwr_pkg::CTL_IDLE:
            begin
                in_stall = 1'b0;
            end
            lfwr_pkg::CTL_EXEC:
            begin
                exec_done = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfwr_pkg::CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A pop follows the head; push and delete look at the requested handle.
    assign rd_addr_next = (action == lfwr_pkg::ACT_POP) ? head_reg[lfwr_pkg::HDL_W-1:0] : handle;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg     <= action;
            hdl_reg     <= handle;
            rd_next_reg <= next_mem[rd_addr_next];
            rd_prev_reg <= prev_mem[handle];
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
    end

    assign hdl_slot   = {1'b0, hdl_reg};
    assign hdl_status = status_reg[hdl_reg];

    // The tail's next link and the head's previous link are always none, so the
    // stored value is not needed for them.
    assign link_nx = (hdl_slot == tail_reg) ? lfwr_pkg::SLOT_NONE : rd_next_reg;
    assign link_pv = (hdl_slot == head_reg) ? lfwr_pkg::SLOT_NONE : rd_prev_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        next_we    = 1'b0;
        next_wa    = hdl_reg;
        next_wd    = lfwr_pkg::SLOT_NONE;
        prev_we    = 1'b0;
        prev_wa    = hdl_reg;
        prev_wd    = lfwr_pkg::SLOT_NONE;
        st_we      = 1'b0;
        st_wa      = hdl_reg;
        st_wd      = lfwr_pkg::ST_IDLE;
        rc         = lfwr_pkg::RC_INVALID;
        got        = '0;
        case (act_reg)
            lfwr_pkg::ACT_PUSH:
            begin
                if (lfwr_pkg::in_pool(hdl_slot) && hdl_status != lfwr_pkg::ST_QUEUED)
                begin
                    rc         = lfwr_pkg::RC_OK;
                    prev_we    = 1'b1;
                    st_we      = 1'b1;
                    st_wd      = lfwr_pkg::ST_QUEUED;
                    count_next = count_reg + 1'b1;
                    tail_next  = hdl_slot;
                    if (!lfwr_pkg::in_pool(tail_reg))
                    begin
                        head_next = hdl_slot;
                        prev_wd   = lfwr_pkg::SLOT_NONE;
                    end
                    else
                    begin
                        next_we = 1'b1;
                        next_wa = tail_reg[lfwr_pkg::HDL_W-1:0];
                        next_wd = hdl_slot;
                        prev_wd = tail_reg;
                    end
                end
            end
            lfwr_pkg::ACT_POP:
            begin
                if (count_reg == '0 || !lfwr_pkg::in_pool(head_reg))
                begin
                    rc = lfwr_pkg::RC_EMPTY;
                end
                else
                begin
                    rc         = lfwr_pkg::RC_OK;
                    got        = head_reg[lfwr_pkg::HDL_W-1:0];
                    st_we      = 1'b1;
                    st_wa      = head_reg[lfwr_pkg::HDL_W-1:0];
                    st_wd      = lfwr_pkg::ST_READ;
                    count_next = count_reg - 1'b1;
                    if (head_reg == tail_reg)
                    begin
                        head_next = lfwr_pkg::SLOT_NONE;
                        tail_next = lfwr_pkg::SLOT_NONE;
                    end
                    else
                    begin
                        head_next = rd_next_reg;
                        if (lfwr_pkg::in_pool(rd_next_reg))
                        begin
                            prev_we = 1'b1;
                            prev_wa = rd_next_reg[lfwr_pkg::HDL_W-1:0];
                            prev_wd = lfwr_pkg::SLOT_NONE;
                        end
                    end
                end
            end
            lfwr_pkg::ACT_DELETE:
            begin
                if (lfwr_pkg::in_pool(hdl_slot))
                begin
                    case (hdl_status)
                        lfwr_pkg::ST_DELETED:
                        begin
                            rc = lfwr_pkg::RC_OK;
                        end
                        lfwr_pkg::ST_READ:
                        begin
                            rc = lfwr_pkg::RC_REFUSED;
                        end
                        lfwr_pkg::ST_QUEUED:
                        begin
                            rc    = lfwr_pkg::RC_OK;
                            st_we = 1'b1;
                            st_wd = lfwr_pkg::ST_DELETED;
                            if (head_reg == hdl_slot)
                            begin
                                head_next = link_nx;
                            end
                            if (tail_reg == hdl_slot)
                            begin
                                tail_next = link_pv;
                            end
                            if (lfwr_pkg::in_pool(link_pv))
                            begin
                                next_we = 1'b1;
                                next_wa = link_pv[lfwr_pkg::HDL_W-1:0];
                                next_wd = link_nx;
                            end
                            if (lfwr_pkg::in_pool(link_nx))
                            begin
                                prev_we = 1'b1;
                                prev_wa = link_nx[lfwr_pkg::HDL_W-1:0];
                                prev_wd = link_pv;
                            end
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            rc = lfwr_pkg::RC_INVALID;
                        end
                    endcase
                end
            end
            default:
            begin
                rc = lfwr_pkg::RC_INVALID;
            end
        endcase
        if (!exec_done)
        begin
            head_next  = head_reg;
            tail_next  = tail_reg;
            count_next = count_reg;
            next_we    = 1'b0;
            prev_we    = 1'b0;
            st_we      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= lfwr_pkg::SLOT_NONE;
            tail_reg  <= lfwr_pkg::SLOT_NONE;
            count_reg <= '0;
            for (int i = 0; i < lfwr_pkg::POOL_SIZE; i++)
            begin
                status_reg[i] <= lfwr_pkg::ST_IDLE;
            end
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (st_we)
            begin
                status_reg[st_wa] <= st_wd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_done)
        begin
            result_code_reg   <= rc;
            popped_handle_reg <= got;
            queue_count_reg   <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_code   = result_code_reg;
    assign popped_handle = popped_handle_reg;
    assign queue_count   = queue_count_reg;

endmodule

@@ hdl/lfwr_checker.sv @@
// Port-level assertions for the linked handle queue and their bind to the top level.
`timescale 1ns / 1ps

module lfwr_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [1:0]                      result_code,
    input logic [lfwr_pkg::HDL_W-1:0]      popped_handle,
    input logic [lfwr_pkg::CNT_W-1:0]      queue_count
);

    // A waiting result stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // Only one transaction is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction accepted back to back");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> queue_count <= lfwr_pkg::CNT_W'(lfwr_pkg::POOL_SIZE))
        else $error("queue count beyond pool size");

    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_code != lfwr_pkg::RC_OK |-> popped_handle == '0)
        else $error("handle reported for a failed request");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_code == lfwr_pkg::RC_EMPTY |-> queue_count == '0)
        else $error("empty pop reported with queued handles");

endmodule

bind linked_fifo_with_removal_core lfwr_checker u_lfwr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_code   (result_code),
    .popped_handle (popped_handle),
    .queue_count   (queue_count)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for the linked handle queue with push, pop, delete and unused-code requests.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 590;

    typedef struct packed {
        logic [1:0]                 action;
        logic [lfwr_pkg::HDL_W-1:0] handle;
    } request_t;

    typedef struct packed {
        logic [1:0]                 code;
        logic [lfwr_pkg::HDL_W-1:0] popped;
        logic [lfwr_pkg::CNT_W-1:0] count;
    } response_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic [1:0]                 action    = '0;
    logic [lfwr_pkg::HDL_W-1:0] handle    = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [1:0]                 result_code;
    logic [lfwr_pkg::HDL_W-1:0] popped_handle;
    logic [lfwr_pkg::CNT_W-1:0] queue_count;

    request_t                   req_backlog [$];
    response_t                  expected_resp [$];
    logic [lfwr_pkg::HDL_W-1:0] recent_pushes [$];

    logic [lfwr_pkg::SLOT_W-1:0] q_head;
    logic [lfwr_pkg::SLOT_W-1:0] q_tail;
    logic [lfwr_pkg::CNT_W-1:0]  q_count;
    logic [lfwr_pkg::SLOT_W-1:0] link_next [lfwr_pkg::POOL_SIZE];
    logic [lfwr_pkg::SLOT_W-1:0] link_prev [lfwr_pkg::POOL_SIZE];
    lfwr_pkg::slot_state_t       slot_st [lfwr_pkg::POOL_SIZE];

    int       send_idle   = 0;
    int       recv_idle   = 0;
    bit       hold_req    = 1'b0;
    bit       hold_ack    = 1'b0;
    int       hold_left   = 0;
    int       quiet_cycles = 0;
    int       errors      = 0;
    int       items_sent  = 0;
    int       results_seen = 0;
    int       code_tally [4] = '{0, 0, 0, 0};
    int       deepest     = 0;
    request_t accepted_req;
    request_t next_req;
    response_t want;

    linked_fifo_with_removal_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .handle        (handle),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_code   (result_code),
        .popped_handle (popped_handle),
        .queue_count   (queue_count)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void clear_queue_state();
        q_head  = lfwr_pkg::SLOT_NONE;
        q_tail  = lfwr_pkg::SLOT_NONE;
        q_count = '0;
        for (int i = 0; i < lfwr_pkg::POOL_SIZE; i++)
        begin
            link_next[i] = '0;
            link_prev[i] = '0;
            slot_st[i]   = lfwr_pkg::ST_IDLE;
        end
    endfunction

    function automatic response_t service_request(request_t req);
        response_t                   rsp;
        logic [lfwr_pkg::HDL_W-1:0]  h;
        logic [lfwr_pkg::SLOT_W-1:0] nx;
        logic [lfwr_pkg::SLOT_W-1:0] pv;
        rsp      = '0;
        rsp.code = lfwr_pkg::RC_OK;
        h        = req.handle;
        case (req.action)
            lfwr_pkg::ACT_PUSH:
            begin
                if (slot_st[h] == lfwr_pkg::ST_QUEUED)
                    rsp.code = lfwr_pkg::RC_INVALID;
                else
                begin
                    if (!(q_tail < lfwr_pkg::SLOT_NONE))
                    begin
                        q_head       = {1'b0, h};
                        q_tail       = {1'b0, h};
                        link_prev[h] = lfwr_pkg::SLOT_NONE;
                    end
                    else
                    begin
                        link_next[q_tail[lfwr_pkg::HDL_W-1:0]] = {1'b0, h};
                        link_prev[h] = q_tail;
                        q_tail       = {1'b0, h};
                    end
                    link_next[h] = lfwr_pkg::SLOT_NONE;
                    slot_st[h]   = lfwr_pkg::ST_QUEUED;
                    q_count      = q_count + 1'b1;
                end
            end
            lfwr_pkg::ACT_POP:
            begin
                if (q_count == 0 || !(q_head < lfwr_pkg::SLOT_NONE))
                    rsp.code = lfwr_pkg::RC_EMPTY;
                else
                begin
                    h = q_head[lfwr_pkg::HDL_W-1:0];
                    if (q_head == q_tail)
                    begin
                        q_head = lfwr_pkg::SLOT_NONE;
                        q_tail = lfwr_pkg::SLOT_NONE;
                    end
                    else
                    begin
                        q_head = link_next[h];
                        if (q_head < lfwr_pkg::SLOT_NONE)
                            link_prev[q_head[lfwr_pkg::HDL_W-1:0]] = lfwr_pkg::SLOT_NONE;
                    end
                    slot_st[h] = lfwr_pkg::ST_READ;
                    q_count    = q_count - 1'b1;
                    rsp.popped = h;
                end
            end
            lfwr_pkg::ACT_DELETE:
            begin
                case (slot_st[h])
                    lfwr_pkg::ST_DELETED: rsp.code = lfwr_pkg::RC_OK;
                    lfwr_pkg::ST_READ:    rsp.code = lfwr_pkg::RC_REFUSED;
                    lfwr_pkg::ST_QUEUED:
                    begin
                        nx         = link_next[h];
                        pv         = link_prev[h];
                        slot_st[h] = lfwr_pkg::ST_DELETED;
                        if (q_head == {1'b0, h})
                            q_head = nx;
                        if (q_tail == {1'b0, h})
                            q_tail = pv;
                        if (pv < lfwr_pkg::SLOT_NONE)
                            link_next[pv[lfwr_pkg::HDL_W-1:0]] = nx;
                        if (nx < lfwr_pkg::SLOT_NONE)
                            link_prev[nx[lfwr_pkg::HDL_W-1:0]] = pv;
                        if (q_count > 0)
                            q_count = q_count - 1'b1;
                    end
                    default:    rsp.code = lfwr_pkg::RC_INVALID;
                endcase
            end
            default: rsp.code = lfwr_pkg::RC_INVALID;
        endcase
        rsp.count = q_count;
        return rsp;
    endfunction

    task automatic queue_request(logic [1:0] act, logic [lfwr_pkg::HDL_W-1:0] hnd);
        request_t r;
        r.action = act;
        r.handle = hnd;
        req_backlog.push_back(r);
    endtask

    task automatic queue_full_fill();
        logic [lfwr_pkg::HDL_W-1:0] order [lfwr_pkg::POOL_SIZE];
        logic [lfwr_pkg::HDL_W-1:0] tmp;
        int                         j;
        for (int i = 0; i < lfwr_pkg::POOL_SIZE; i++)
            order[i] = lfwr_pkg::HDL_W'(i);
        for (int i = lfwr_pkg::POOL_SIZE - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < lfwr_pkg::POOL_SIZE; i++)
            queue_request(lfwr_pkg::ACT_PUSH, order[i]);
    endtask

    task automatic queue_random_phase(int n);
        int                         push_w;
        int                         pop_w;
        int                         del_w;
        int                         pick;
        logic [lfwr_pkg::HDL_W-1:0] hnd;
        push_w = 35;
        pop_w  = 30;
        del_w  = 31;
        for (int i = 0; i < n; i++)
        begin
            if (i % 200 == 0)
                queue_full_fill();
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       begin push_w = 65; pop_w = 15; del_w = 16; end
                    1:       begin push_w = 15; pop_w = 50; del_w = 31; end
                    default: begin push_w = 35; pop_w = 30; del_w = 31; end
                endcase
            end
            pick = $urandom_range(99);
            hnd  = lfwr_pkg::HDL_W'($urandom_range(lfwr_pkg::POOL_SIZE - 1));
            if (pick < push_w)
            begin
                queue_request(lfwr_pkg::ACT_PUSH, hnd);
                recent_pushes.push_back(hnd);
                if (recent_pushes.size() > 8)
                    void'(recent_pushes.pop_front());
            end
            else if (pick < push_w + pop_w)
                queue_request(lfwr_pkg::ACT_POP, hnd);
            else if (pick < push_w + pop_w + del_w)
            begin
                if (recent_pushes.size() != 0 && $urandom_range(1) == 1)
                    hnd = recent_pushes[$urandom_range(recent_pushes.size() - 1)];
                queue_request(lfwr_pkg::ACT_DELETE, hnd);
            end
            else
                queue_request(ACT_UNUSED, hnd);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || in_valid || expected_resp.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action   <= '0;
            handle   <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                accepted_req.action = action;
                accepted_req.handle = handle;
                expected_resp.push_back(service_request(accepted_req));
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    next_req = req_backlog.pop_front();
                    in_valid <= 1'b1;
                    action   <= next_req.action;
                    handle   <= next_req.handle;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_resp.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction, actual code %0d handle %0d count %0d",
                             $time, result_code, popped_handle, queue_count);
                end
                else
                begin
                    want = expected_resp.pop_front();
                    code_tally[result_code]++;
                    if (queue_count > deepest)
                        deepest = queue_count;
                    if (result_code !== want.code)
                    begin
                        errors++;
                        $display("%0t: result_code expected %0d actual %0d",
                                 $time, want.code, result_code);
                    end
                    if (popped_handle !== want.popped)
                    begin
                        errors++;
                        $display("%0t: popped_handle expected %0d actual %0d",
                                 $time, want.popped, popped_handle);
                    end
                    if (queue_count !== want.count)
                    begin
                        errors++;
                        $display("%0t: queue_count expected %0d actual %0d",
                                 $time, want.count, queue_count);
                    end
                end
            end
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        clear_queue_state();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_request(lfwr_pkg::ACT_POP, 4'd0);
        queue_request(lfwr_pkg::ACT_DELETE, 4'd0);
        queue_request(ACT_UNUSED, 4'd15);
        queue_request(lfwr_pkg::ACT_PUSH, 4'd0);
        queue_request(lfwr_pkg::ACT_PUSH, 4'd15);
        queue_request(lfwr_pkg::ACT_PUSH, 4'd0);
        queue_request(lfwr_pkg::ACT_PUSH, 4'd5);
        queue_request(lfwr_pkg::ACT_PUSH, 4'd10);
        queue_request(lfwr_pkg::ACT_DELETE, 4'd15);
        queue_request(lfwr_pkg::ACT_DELETE, 4'd15);
        queue_request(lfwr_pkg::ACT_POP, 4'd15);
        queue_request(lfwr_pkg::ACT_DELETE, 4'd0);
        queue_request(lfwr_pkg::ACT_POP, 4'd0);
        queue_request(lfwr_pkg::ACT_DELETE, 4'd10);
        queue_request(lfwr_pkg::ACT_POP, 4'd0);
        queue_request(lfwr_pkg::ACT_PUSH, 4'd15);
        queue_request(lfwr_pkg::ACT_PUSH, 4'd0);
        queue_request(lfwr_pkg::ACT_PUSH, 4'd7);
        queue_request(lfwr_pkg::ACT_DELETE, 4'd7);
        queue_request(lfwr_pkg::ACT_DELETE, 4'd15);
        queue_request(lfwr_pkg::ACT_POP, 4'd0);
        queue_request(lfwr_pkg::ACT_PUSH, 4'd3);
        queue_request(ACT_UNUSED, 4'd0);
        queue_request(lfwr_pkg::ACT_POP, 4'd0);
        wait_drained();

        send_idle = 31;
        recv_idle = 74;
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        send_idle = 74;
        recv_idle = 31;
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        queue_random_phase(PHASE_ITEMS);
        hold_req = ~hold_req;
        wait_drained();

        if (expected_resp.size() != 0)
        begin
            errors += expected_resp.size();
            $display("%0t: %0d expected transactions never arrived",
                     $time, expected_resp.size());
        end
        $display("Covered %0d requests and %0d results under three idling mixes and a hold-off.",
                 items_sent, results_seen);
        $display("Codes: ok %0d, empty %0d, refused %0d, invalid %0d; deepest queue %0d.",
                 code_tally[lfwr_pkg::RC_OK], code_tally[lfwr_pkg::RC_EMPTY],
                 code_tally[lfwr_pkg::RC_REFUSED], code_tally[lfwr_pkg::RC_INVALID], deepest);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
